// File: rtl/etmb_pkg.sv
package etmb_pkg;

  typedef logic signed [31:0] elem_t;

  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 28;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
  localparam elem_t ELEM_MIN = 32'sh8000_0000;

  // arctangent of 2^-i as a fraction of a full turn (2^32 per turn)
  function automatic logic [31:0] atan_phase(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Q30 product back to Q30, half added then floored
  function automatic elem_t rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[31:0];
  endfunction

  // wide product back to 30 fewer fraction bits, saturated to 32 bits
  function automatic elem_t sat_q30(input logic signed [64:0] p);
    logic signed [64:0] t;
    elem_t v;
    t = (p + 65'sd536870912) >>> 30;
    if (t > 65'sd2147483647) begin
      v = ELEM_MAX;
    end else if (t < -65'sd2147483648) begin
      v = ELEM_MIN;
    end else begin
      v = t[31:0];
    end
    return v;
  endfunction

endpackage

// File: rtl/euler_transform_matrix_builder.sv
// Euler (Y-X-Z) rotation, scale and translation to model and normal matrices.
// Input channel: in_valid / in_stall carry one request of three angles
// (2^ANGLE_BITS per turn), three scales and a translation (signed, with
// VALUE_FRAC_BITS fraction bits). Result channel: out_valid / out_stall carry
// seven column requests per input: model columns 0..3, then normal columns
// 0..2; out_last_column marks normal column 2.
// The first column leaves after the front stages and the operand, product and
// output registers; the rest follow one per cycle while the receiver does not
// stall. Throughput is set by the single column multiplier bank that serves all
// seven columns; a finished input waits until its seventh column issues. The
// front pipeline (three 28-step CORDIC pipes, product stages, a bit-per-stage
// reciprocal divider) takes an input every cycle while it has room.
// Reset clears every valid bit and the column counter; no clearing pass.
// When the receiver stalls, the output register holds, the column stages
// freeze, and once the finished-input register is occupied in_stall rises;
// nothing is dropped or repeated.
module euler_transform_matrix_builder #(
  parameter int ANGLE_BITS      = 16,
  parameter int VALUE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_rot_x,
  input  logic [15:0] in_rot_y,
  input  logic [15:0] in_rot_z,
  input  logic signed [31:0] in_scale_x,
  input  logic signed [31:0] in_scale_y,
  input  logic signed [31:0] in_scale_z,
  input  logic signed [31:0] in_trans_x,
  input  logic signed [31:0] in_trans_y,
  input  logic signed [31:0] in_trans_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matrix_select,
  output logic [1:0]  out_column_index,
  output logic signed [31:0] out_elem0,
  output logic signed [31:0] out_elem1,
  output logic signed [31:0] out_elem2,
  output logic signed [31:0] out_elem3,
  output logic        out_last_column
);

  // reciprocal divider length sets the front depth
  localparam int DW  = (2*VALUE_FRAC_BITS + 1 > 31) ? 2*VALUE_FRAC_BITS + 1 : 31;
  localparam int FD  = DW + 2;
  localparam int PAD = FD - 33;  // angle delay so rotation lands with reciprocals

  localparam logic [2:0] COL_M0 = 3'd0;
  localparam logic [2:0] COL_M1 = 3'd1;
  localparam logic [2:0] COL_M2 = 3'd2;
  localparam logic [2:0] COL_T  = 3'd3;
  localparam logic [2:0] COL_N0 = 3'd4;
  localparam logic [2:0] COL_N1 = 3'd5;
  localparam logic [2:0] COL_N2 = 3'd6;

  localparam etmb_pkg::elem_t ONE_Q   = 32'sd1 <<< VALUE_FRAC_BITS;
  localparam etmb_pkg::elem_t ONE_Q30 = 32'sd1 <<< 30;

  typedef struct packed {
    etmb_pkg::elem_t x;
    etmb_pkg::elem_t y;
    etmb_pkg::elem_t z;
  } trans_t;

  logic fen;  // front pipeline advance
  logic ben;  // column stages advance
  logic bv;   // finished input waiting in the last front stage

  logic v_r [FD];

  // ---------------- front: angles ----------------
  logic [15:0] ax, ay, az;

  if (PAD > 0) begin : g_pad
    logic [15:0] dx_r [PAD];
    logic [15:0] dy_r [PAD];
    logic [15:0] dz_r [PAD];
    always_ff @(posedge clk) begin
      if (fen) begin
        dx_r[0] <= in_rot_x;
        dy_r[0] <= in_rot_y;
        dz_r[0] <= in_rot_z;
        for (int i = 1; i < PAD; i++) begin
          dx_r[i] <= dx_r[i-1];
          dy_r[i] <= dy_r[i-1];
          dz_r[i] <= dz_r[i-1];
        end
      end
    end
    assign ax = dx_r[PAD-1];
    assign ay = dy_r[PAD-1];
    assign az = dz_r[PAD-1];
  end else begin : g_nopad
    assign ax = in_rot_x;
    assign ay = in_rot_y;
    assign az = in_rot_z;
  end

  // c1/s1 from Y, c2/s2 from X, c3/s3 from Z
  etmb_pkg::elem_t s1, c1, s2, c2, s3, c3;

  etmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_cs_y (
    .clk(clk), .en(fen), .angle(ay), .sin_o(s1), .cos_o(c1)
  );
  etmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_cs_x (
    .clk(clk), .en(fen), .angle(ax), .sin_o(s2), .cos_o(c2)
  );
  etmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_cs_z (
    .clk(clk), .en(fen), .angle(az), .sin_o(s3), .cos_o(c3)
  );

  // first products
  logic signed [63:0] p_c1c3_r, p_s1s2_r, p_c1s2_r, p_c3s1_r, p_c1s3_r;
  logic signed [63:0] p_c2s3_r, p_c2c3_r, p_s1s3_r, p_c2s1_r, p_c1c2_r;
  etmb_pkg::elem_t    m1_s2_r, m1_s3_r;
  // rounded
  etmb_pkg::elem_t q_c1c3_r, q_s1s2_r, q_c1s2_r, q_c3s1_r, q_c1s3_r;
  etmb_pkg::elem_t q_c2s3_r, q_c2c3_r, q_s1s3_r, q_c2s1_r, q_c1c2_r;
  etmb_pkg::elem_t r1_s2_r, r1_s3_r;
  // second products
  logic signed [63:0] m_a_r, m_b_r, m_c_r, m_d_r;
  etmb_pkg::elem_t t_c1c3_r, t_c3s1_r, t_c1s3_r, t_c2s3_r, t_c2c3_r;
  etmb_pkg::elem_t t_s1s3_r, t_c2s1_r, t_c1c2_r, t_s2_r;
  // rotation, r_r[col][row]
  logic signed [32:0] r_r [3][3];

  always_ff @(posedge clk) begin
    if (fen) begin
      p_c1c3_r <= c1 * c3;
      p_s1s2_r <= s1 * s2;
      p_c1s2_r <= c1 * s2;
      p_c3s1_r <= c3 * s1;
      p_c1s3_r <= c1 * s3;
      p_c2s3_r <= c2 * s3;
      p_c2c3_r <= c2 * c3;
      p_s1s3_r <= s1 * s3;
      p_c2s1_r <= c2 * s1;
      p_c1c2_r <= c1 * c2;
      m1_s2_r  <= s2;
      m1_s3_r  <= s3;

      q_c1c3_r <= etmb_pkg::rnd_q30(p_c1c3_r);
      q_s1s2_r <= etmb_pkg::rnd_q30(p_s1s2_r);
      q_c1s2_r <= etmb_pkg::rnd_q30(p_c1s2_r);
      q_c3s1_r <= etmb_pkg::rnd_q30(p_c3s1_r);
      q_c1s3_r <= etmb_pkg::rnd_q30(p_c1s3_r);
      q_c2s3_r <= etmb_pkg::rnd_q30(p_c2s3_r);
      q_c2c3_r <= etmb_pkg::rnd_q30(p_c2c3_r);
      q_s1s3_r <= etmb_pkg::rnd_q30(p_s1s3_r);
      q_c2s1_r <= etmb_pkg::rnd_q30(p_c2s1_r);
      q_c1c2_r <= etmb_pkg::rnd_q30(p_c1c2_r);
      r1_s2_r  <= m1_s2_r;
      r1_s3_r  <= m1_s3_r;

      m_a_r    <= q_s1s2_r * r1_s3_r;
      m_b_r    <= q_c1s2_r * r1_s3_r;
      m_c_r    <= q_c3s1_r * r1_s2_r;
      m_d_r    <= q_c1c3_r * r1_s2_r;
      t_c1c3_r <= q_c1c3_r;
      t_c3s1_r <= q_c3s1_r;
      t_c1s3_r <= q_c1s3_r;
      t_c2s3_r <= q_c2s3_r;
      t_c2c3_r <= q_c2c3_r;
      t_s1s3_r <= q_s1s3_r;
      t_c2s1_r <= q_c2s1_r;
      t_c1c2_r <= q_c1c2_r;
      t_s2_r   <= r1_s2_r;

      r_r[0][0] <= 33'(t_c1c3_r) + 33'(etmb_pkg::rnd_q30(m_a_r));
      r_r[0][1] <= 33'(t_c2s3_r);
      r_r[0][2] <= 33'(etmb_pkg::rnd_q30(m_b_r)) - 33'(t_c3s1_r);
      r_r[1][0] <= 33'(etmb_pkg::rnd_q30(m_c_r)) - 33'(t_c1s3_r);
      r_r[1][1] <= 33'(t_c2c3_r);
      r_r[1][2] <= 33'(etmb_pkg::rnd_q30(m_d_r)) + 33'(t_s1s3_r);
      r_r[2][0] <= 33'(t_c2s1_r);
      r_r[2][1] <= -33'(t_s2_r);
      r_r[2][2] <= 33'(t_c1c2_r);
    end
  end

  // ---------------- front: reciprocals and translation ----------------
  etmb_pkg::elem_t sc_x, sc_y, sc_z, inv_x, inv_y, inv_z;

  etmb_recip #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_rc_x (
    .clk(clk), .en(fen), .scale_i(in_scale_x), .scale_o(sc_x), .recip_o(inv_x)
  );
  etmb_recip #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_rc_y (
    .clk(clk), .en(fen), .scale_i(in_scale_y), .scale_o(sc_y), .recip_o(inv_y)
  );
  etmb_recip #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_rc_z (
    .clk(clk), .en(fen), .scale_i(in_scale_z), .scale_o(sc_z), .recip_o(inv_z)
  );

  trans_t td_r [FD];

  always_ff @(posedge clk) begin
    if (fen) begin
      td_r[0] <= '{x: in_trans_x, y: in_trans_y, z: in_trans_z};
      for (int i = 1; i < FD; i++) begin
        td_r[i] <= td_r[i-1];
      end
    end
  end

  // valid bits travel alongside the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FD; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (fen) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < FD; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // ---------------- column sequencer ----------------
  logic [2:0] col_r;

  assign bv       = v_r[FD-1];
  assign ben      = !out_valid || !out_stall;
  // free the last front stage only as the seventh column issues
  assign fen      = !bv || (ben && col_r == COL_N2);
  assign in_stall = !fen;

  logic signed [32:0] e0_c, e1_c, e2_c;
  etmb_pkg::elem_t    f_c;
  logic               sel_c, tcol_c, last_c;
  logic [1:0]         cidx_c;

  always_comb begin
    e0_c   = '0;
    e1_c   = '0;
    e2_c   = '0;
    f_c    = '0;
    sel_c  = 1'b0;
    tcol_c = 1'b0;
    last_c = 1'b0;
    cidx_c = '0;
    unique case (col_r)
      COL_M0: begin
        e0_c = r_r[0][0]; e1_c = r_r[0][1]; e2_c = r_r[0][2];
        f_c  = sc_x; cidx_c = 2'd0;
      end
      COL_M1: begin
        e0_c = r_r[1][0]; e1_c = r_r[1][1]; e2_c = r_r[1][2];
        f_c  = sc_y; cidx_c = 2'd1;
      end
      COL_M2: begin
        e0_c = r_r[2][0]; e1_c = r_r[2][1]; e2_c = r_r[2][2];
        f_c  = sc_z; cidx_c = 2'd2;
      end
      COL_T: begin
        // translation passes the multipliers unchanged: times one in Q30
        e0_c = 33'(td_r[FD-1].x); e1_c = 33'(td_r[FD-1].y); e2_c = 33'(td_r[FD-1].z);
        f_c  = ONE_Q30; cidx_c = 2'd3; tcol_c = 1'b1;
      end
      COL_N0: begin
        e0_c = r_r[0][0]; e1_c = r_r[0][1]; e2_c = r_r[0][2];
        f_c  = inv_x; cidx_c = 2'd0; sel_c = 1'b1;
      end
      COL_N1: begin
        e0_c = r_r[1][0]; e1_c = r_r[1][1]; e2_c = r_r[1][2];
        f_c  = inv_y; cidx_c = 2'd1; sel_c = 1'b1;
      end
      COL_N2: begin
        e0_c = r_r[2][0]; e1_c = r_r[2][1]; e2_c = r_r[2][2];
        f_c  = inv_z; cidx_c = 2'd2; sel_c = 1'b1; last_c = 1'b1;
      end
      default: begin
        e0_c = '0;
      end
    endcase
  end

  // operand stage
  logic               a_v_r, a_sel_r, a_tcol_r, a_last_r;
  logic [1:0]         a_cidx_r;
  logic signed [32:0] a_e_r [3];
  etmb_pkg::elem_t    a_f_r;
  // product stage
  logic               b_v_r, b_sel_r, b_tcol_r, b_last_r;
  logic [1:0]         b_cidx_r;
  logic signed [64:0] b_p_r [3];
  // output register
  logic               o_v_r, o_sel_r, o_last_r;
  logic [1:0]         o_cidx_r;
  etmb_pkg::elem_t    o_e_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= COL_M0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (ben) begin
      a_v_r <= bv;
      b_v_r <= a_v_r;
      o_v_r <= b_v_r;
      if (bv) begin
        col_r <= (col_r == COL_N2) ? COL_M0 : col_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ben) begin
      a_sel_r  <= sel_c;
      a_tcol_r <= tcol_c;
      a_last_r <= last_c;
      a_cidx_r <= cidx_c;
      a_e_r[0] <= e0_c;
      a_e_r[1] <= e1_c;
      a_e_r[2] <= e2_c;
      a_f_r    <= f_c;

      b_sel_r  <= a_sel_r;
      b_tcol_r <= a_tcol_r;
      b_last_r <= a_last_r;
      b_cidx_r <= a_cidx_r;
      for (int i = 0; i < 3; i++) begin
        b_p_r[i] <= 65'(a_e_r[i]) * 65'(a_f_r);
      end

      o_sel_r  <= b_sel_r;
      o_last_r <= b_last_r;
      o_cidx_r <= b_cidx_r;
      for (int i = 0; i < 3; i++) begin
        o_e_r[i] <= etmb_pkg::sat_q30(b_p_r[i]);
      end
      o_e_r[3] <= b_tcol_r ? ONE_Q : '0;
    end
  end

  assign out_valid         = o_v_r;
  assign out_matrix_select = o_sel_r;
  assign out_column_index  = o_cidx_r;
  assign out_elem0         = o_e_r[0];
  assign out_elem1         = o_e_r[1];
  assign out_elem2         = o_e_r[2];
  assign out_elem3         = o_e_r[3];
  assign out_last_column   = o_last_r;

  // ---------------- checks ----------------
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_N2)
    else $error("column counter out of range");

  a_col_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    col_r != COL_M0 |-> bv)
    else $error("column run without a finished input");

  // the columns may still advance, but the finished input stays put
  a_bundle_held: assert property (@(posedge clk) disable iff (!rst_n)
    bv && !fen |=> bv)
    else $error("finished input lost while columns still due");

  a_last_is_n2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_column |-> out_matrix_select && out_column_index == 2'd2)
    else $error("last column flag on the wrong column");

  a_trans_row3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matrix_select && out_column_index == 2'd3 |-> out_elem3 == ONE_Q)
    else $error("translation column row 3 not one");

endmodule

// File: rtl/etmb_sincos.sv
module etmb_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [etmb_pkg::ANGLE_W-1:0]  angle,
  output etmb_pkg::elem_t               sin_o,
  output etmb_pkg::elem_t               cos_o
);

  localparam int N  = etmb_pkg::CORDIC_STEPS;
  localparam int XW = 34;
  localparam int ZW = 33;

  logic [ANGLE_BITS-1:0] ang;
  logic [31:0]           ph;
  logic                  flip;
  logic [31:0]           phf;

  logic signed [XW-1:0] x_r [N+1];
  logic signed [XW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic                 flip_r [N+1];

  // fold into [-quarter, quarter) turn, note the half-turn flip
  assign ang  = ANGLE_BITS'(angle);
  assign ph   = {ang, {(32-ANGLE_BITS){1'b0}}};
  assign flip = ph[31] ^ ph[30];
  assign phf  = {ph[31] ^ flip, ph[30:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= XW'(etmb_pkg::CORDIC_GAIN_Q30);
      y_r[0]    <= '0;
      z_r[0]    <= {phf[31], phf};
      flip_r[0] <= flip;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] at;
    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;
    assign at = {1'b0, etmb_pkg::atan_phase(5'(k))};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][ZW-1]) begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - at;
        end else begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + at;
        end
        flip_r[k+1] <= flip_r[k];
      end
    end
  end

  assign sin_o = flip_r[N] ? -y_r[N][31:0] : y_r[N][31:0];
  assign cos_o = flip_r[N] ? -x_r[N][31:0] : x_r[N][31:0];

endmodule

// File: rtl/etmb_recip.sv
module etmb_recip #(
  parameter int VALUE_FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            en,
  input  etmb_pkg::elem_t scale_i,
  output etmb_pkg::elem_t scale_o,
  output etmb_pkg::elem_t recip_o
);

  localparam int DW = (2*VALUE_FRAC_BITS + 1 > 31) ? 2*VALUE_FRAC_BITS + 1 : 31;
  localparam logic [DW-1:0] NUM_BASE = {{(DW-1){1'b0}}, 1'b1} << (2*VALUE_FRAC_BITS);
  localparam logic [DW:0] POS_LIM = (DW+1)'(32'h7FFF_FFFF);
  localparam logic [DW:0] NEG_LIM = (DW+1)'(32'h8000_0000);

  logic [31:0] mag_c;

  logic [31:0]     rem_r  [DW+1];
  logic [DW-1:0]   num_r  [DW+1];
  logic [DW-1:0]   q_r    [DW+1];
  logic [31:0]     mag_r  [DW+1];
  logic            neg_r  [DW+1];
  logic            zero_r [DW+1];
  etmb_pkg::elem_t sc_r   [DW+1];
  etmb_pkg::elem_t recip_r;
  etmb_pkg::elem_t scale_r;
  logic [DW:0]     qe;

  assign mag_c = scale_i[31] ? (~scale_i + 32'd1) : scale_i;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      num_r[0]  <= NUM_BASE + DW'({1'b0, mag_c[31:1]});
      q_r[0]    <= '0;
      mag_r[0]  <= mag_c;
      neg_r[0]  <= scale_i[31];
      zero_r[0] <= (scale_i == '0);
      sc_r[0]   <= scale_i;
    end
  end

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [32:0] tr;
    logic [32:0] df;
    logic        ge;
    assign tr = {rem_r[k], num_r[k][DW-1]};
    assign df = tr - {1'b0, mag_r[k]};
    assign ge = (tr >= {1'b0, mag_r[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? df[31:0] : tr[31:0];
        num_r[k+1]  <= num_r[k] << 1;
        q_r[k+1]    <= {q_r[k][DW-2:0], ge};
        mag_r[k+1]  <= mag_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        sc_r[k+1]   <= sc_r[k];
      end
    end
  end

  assign qe = {1'b0, q_r[DW]};

  always_ff @(posedge clk) begin
    if (en) begin
      scale_r <= sc_r[DW];
      if (zero_r[DW]) begin
        recip_r <= etmb_pkg::ELEM_MAX;
      end else if (!neg_r[DW]) begin
        recip_r <= (qe > POS_LIM) ? etmb_pkg::ELEM_MAX : qe[31:0];
      end else begin
        recip_r <= (qe > NEG_LIM) ? etmb_pkg::ELEM_MIN : -qe[31:0];
      end
    end
  end

  assign scale_o = scale_r;
  assign recip_o = recip_r;

endmodule
